>>> rtl/isp_pkg.sv
package isp_pkg;
  localparam int unsigned TrackerCountDefault = 64;
  localparam int unsigned PageShiftDefault = 12;
  localparam int unsigned MaxDegree = 8;
  localparam int unsigned AddrWidth = 64;
  localparam int unsigned DegreeWidth = 4;
  localparam logic [DegreeWidth-1:0] DegreeReset = 4'd1;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [0:0] {
    REG_DEGREE = 1'b0
  } reg_index_t;
endpackage

>>> rtl/isp_table.sv
module isp_table #(
  parameter int unsigned TRACKER_COUNT = 64,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [63:0] in_addr,
  input  logic [63:0] in_ip,
  output logic cmd_valid,
  input  logic cmd_ready,
  output logic [64-PAGE_SHIFT-1:0] cmd_page,
  output logic [65-PAGE_SHIFT-1:0] cmd_stride
);
  import isp_pkg::*;
  localparam int unsigned PW = 64 - PAGE_SHIFT;
  localparam int unsigned SW = 65 - PAGE_SHIFT;
  localparam int unsigned IW = (TRACKER_COUNT > 1) ? $clog2(TRACKER_COUNT) : 1;

  logic [63:0] t_ip [TRACKER_COUNT];
  logic [PW-1:0] t_page [TRACKER_COUNT];
  logic [SW-1:0] t_stride [TRACKER_COUNT];
  logic [IW-1:0] t_rank [TRACKER_COUNT];

  // Stage 1: registered lookup results
  logic busy;
  logic [PW-1:0] s_page;
  logic s_hit;
  logic [IW-1:0] s_slot;
  logic [63:0] in_ip_q;

  logic hit_c;
  logic [IW-1:0] hit_slot_c, lru_slot_c;
  always_comb begin
    hit_c = 1'b0;
    hit_slot_c = '0;
    lru_slot_c = IW'(TRACKER_COUNT - 1);
    for (int i = TRACKER_COUNT - 1; i >= 0; i--) begin
      if (t_ip[i] == in_ip) begin
        hit_c = 1'b1;
        hit_slot_c = IW'(i);
      end
      if (t_rank[i] == IW'(TRACKER_COUNT - 1)) lru_slot_c = IW'(i);
    end
  end

  logic [SW-1:0] stride_c;
  logic [IW-1:0] old_rank;
  logic repeat_c, promote_c, emit_stall;
  assign stride_c = {1'b0, s_page} - {1'b0, t_page[s_slot]};
  assign old_rank = t_rank[s_slot];
  assign repeat_c = s_hit && (stride_c != '0) && (stride_c == t_stride[s_slot]);
  assign emit_stall = repeat_c && !cmd_ready;
  assign promote_c = busy && !emit_stall && (!s_hit || stride_c != '0);
  assign in_ready = !busy;
  assign cmd_valid = busy && repeat_c;
  assign cmd_page = s_page;
  assign cmd_stride = stride_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      for (int i = 0; i < TRACKER_COUNT; i++) begin
        t_ip[i] <= '0;
        t_page[i] <= '0;
        t_stride[i] <= '0;
        t_rank[i] <= IW'(i);
      end
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        s_page <= in_addr[63:PAGE_SHIFT];
        s_hit <= hit_c;
        s_slot <= hit_c ? hit_slot_c : lru_slot_c;
      end else if (busy && !emit_stall) begin
        busy <= 1'b0;
      end
      if (promote_c) begin
        for (int i = 0; i < TRACKER_COUNT; i++) begin
          if (t_rank[i] < old_rank) t_rank[i] <= t_rank[i] + 1'b1;
        end
        t_rank[s_slot] <= '0;
        t_page[s_slot] <= s_page;
        if (!s_hit) begin
          t_ip[s_slot] <= in_ip_q;
          t_stride[s_slot] <= '0;
        end else begin
          t_stride[s_slot] <= stride_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_ip_q <= in_ip;
  end

`ifndef ASSERT_OFF
  a_cmd_only_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> busy) else $error("command without lookup");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("accept while busy");
  a_mru_promoted: assert property (@(posedge clk) disable iff (rst)
    promote_c |=> t_rank[$past(s_slot)] == '0) else $error("promotion lost");
`endif
endmodule

>>> rtl/isp_issue.sv
module isp_issue #(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  logic [64-PAGE_SHIFT-1:0] cmd_page,
  input  logic [65-PAGE_SHIFT-1:0] cmd_stride,
  input  logic [isp_pkg::DegreeWidth-1:0] degree,
  output logic out_valid,
  input  logic out_ready,
  output logic [63:0] out_addr,
  output logic out_last
);
  import isp_pkg::*;
  localparam int unsigned PW = 64 - PAGE_SHIFT;

  // Queue of commands between lookup and issue
  logic [PW-1:0] q_page [QueueDepth];
  logic [PW-1:0] q_stride [QueueDepth];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  assign cmd_ready = (cnt != 2'(QueueDepth));

  logic [3:0] deg_sat;
  assign deg_sat = (degree > 4'(MaxDegree)) ? 4'(MaxDegree) : degree;

  logic active;
  logic [PW-1:0] target, stride;
  logic [3:0] k;
  logic [PW-1:0] nxt;
  assign nxt = target + stride;
  assign out_valid = active;
  assign out_addr = {target, {PAGE_SHIFT{1'b0}}};
  assign out_last = (k == deg_sat);

  logic pop, push;
  assign push = cmd_valid && cmd_ready;
  assign pop = (cnt != 2'd0) && (!active || (out_valid && out_ready && out_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; active <= 1'b0; k <= '0;
    end else begin
      if (push) begin
        q_page[wp] <= cmd_page;
        q_stride[wp] <= cmd_stride[PW-1:0];
        wp <= wp + 1'b1;
      end
      // A command popped at degree zero is dropped without a run.
      cnt <= cnt + 2'(push) - 2'(pop);
      if (pop) rp <= rp + 1'b1;
      if (pop && deg_sat != '0) begin
        active <= 1'b1;
        target <= q_page[rp] + q_stride[rp];
        stride <= q_stride[rp];
        k <= 4'd1;
      end else if (active && out_ready) begin
        if (out_last) active <= 1'b0;
        target <= nxt;
        k <= k + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'(QueueDepth)) else $error("queue overflow");
  a_k: assert property (@(posedge clk) disable iff (rst)
    active |-> (k != 4'd0 && k <= deg_sat)) else $error("count out of range");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (active && !out_ready) |=> active) else $error("run dropped");
`endif
endmodule

>>> rtl/ip_stride_prefetcher.sv
// Channel     | handshake             | payload
// input       | in_valid / in_ready   | access_address, instr_pointer
// output      | out_valid / out_ready | prefetch_address, last_of_run
// config      | APB psel/penable      | degree register at byte address 0
// Flow: the lookup stage matches an input transfer, then updates its tracker;
// a repeated stride queues one command and the issue stage emits one transfer
// per cycle while out_ready is high, min(degree, 8) transfers per command.
// Reset: rst clears all trackers, LRU ranks to entry index, degree to 1.
// Stalls: the lookup stage holds when the command queue is full; issue holds
// on out_ready low.
module ip_stride_prefetcher #(
  parameter int unsigned TRACKER_COUNT = isp_pkg::TrackerCountDefault,
  parameter int unsigned PAGE_SHIFT = isp_pkg::PageShiftDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [63:0] access_address,
  input  logic [63:0] instr_pointer,
  output logic out_valid,
  input  logic out_ready,
  output logic [63:0] prefetch_address,
  output logic last_of_run,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import isp_pkg::*;

  localparam logic [1:0] DegreeAddr = 2'(4 * REG_DEGREE);

  logic [DegreeWidth-1:0] degree;
  logic cv, cr;
  logic [64-PAGE_SHIFT-1:0] cp;
  logic [65-PAGE_SHIFT-1:0] cs;

  // Write the degree register on the access phase; other addresses drop.
  assign pready = 1'b1;
  assign prdata = (paddr == DegreeAddr) ? {28'd0, degree} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DegreeReset;
    end else if (psel && penable && pwrite && paddr == DegreeAddr) begin
      degree <= pwdata[DegreeWidth-1:0];
    end
  end

  isp_table #(.TRACKER_COUNT(TRACKER_COUNT), .PAGE_SHIFT(PAGE_SHIFT)) u_table (
    .clk, .rst, .in_valid, .in_ready,
    .in_addr(access_address), .in_ip(instr_pointer),
    .cmd_valid(cv), .cmd_ready(cr), .cmd_page(cp), .cmd_stride(cs)
  );

  isp_issue #(.PAGE_SHIFT(PAGE_SHIFT)) u_issue (
    .clk, .rst, .cmd_valid(cv), .cmd_ready(cr), .cmd_page(cp), .cmd_stride(cs),
    .degree, .out_valid, .out_ready, .out_addr(prefetch_address),
    .out_last(last_of_run)
  );
endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import isp_pkg::*;

  localparam int unsigned Trackers = 64;
  localparam int unsigned PgShift = 12;
  localparam int unsigned CycleLimit = 400000;

  // Golden copy of the tracker table, plus a FIFO of expected prefetches.
  class prefetch_scoreboard;
    logic [63:0] ip_tab[Trackers];
    logic [63:0] page_tab[Trackers];
    logic [63:0] stride_tab[Trackers];
    int unsigned rank_tab[Trackers];
    logic [3:0] degree;
    logic [63:0] pending_addr[$];
    logic pending_last[$];
    int errors;

    function void clear();
      for (int i = 0; i < Trackers; i++) begin
        ip_tab[i] = '0;
        page_tab[i] = '0;
        stride_tab[i] = '0;
        rank_tab[i] = i;
      end
      degree = DegreeReset;
      errors = 0;
    endfunction

    function void promote(int slot);
      int unsigned old_rank;
      old_rank = rank_tab[slot];
      for (int i = 0; i < Trackers; i++)
        if (rank_tab[i] < old_rank) rank_tab[i]++;
      rank_tab[slot] = 0;
    endfunction

    function void note_access(logic [63:0] addr, logic [63:0] ip);
      logic [63:0] page;
      logic [63:0] stride;
      logic [63:0] target;
      int slot;
      int count;
      page = addr >> PgShift;
      slot = -1;
      for (int i = 0; i < Trackers; i++)
        if (slot < 0 && ip_tab[i] == ip) slot = i;
      if (slot < 0) begin
        // Replace the least recent tracker.
        slot = Trackers - 1;
        for (int i = Trackers - 1; i >= 0; i--)
          if (rank_tab[i] == Trackers - 1) slot = i;
        ip_tab[slot] = ip;
        page_tab[slot] = page;
        stride_tab[slot] = '0;
        promote(slot);
        return;
      end
      stride = page - page_tab[slot];
      if (stride == 0) return;
      if (stride == stride_tab[slot]) begin
        count = (degree > MaxDegree) ? MaxDegree : degree;
        target = page;
        for (int k = 0; k < count; k++) begin
          target += stride;
          pending_addr.push_back(target << PgShift);
          pending_last.push_back(k + 1 == count);
        end
      end
      page_tab[slot] = page;
      stride_tab[slot] = stride;
      promote(slot);
    endfunction

    function void check_prefetch(logic [63:0] addr, logic last);
      logic [63:0] exp_addr;
      logic exp_last;
      if (pending_addr.size() == 0) begin
        $error("unexpected prefetch_address %h", addr);
        errors++;
        return;
      end
      exp_addr = pending_addr.pop_front();
      exp_last = pending_last.pop_front();
      if (addr !== exp_addr) begin
        $error("prefetch_address expected %h actual %h", exp_addr, addr);
        errors++;
      end
      if (last !== exp_last) begin
        $error("last_of_run expected %b actual %b", exp_last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [63:0] access_address;
  logic [63:0] instr_pointer;
  logic out_valid;
  logic out_ready;
  logic [63:0] prefetch_address;
  logic last_of_run;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  prefetch_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int unsigned cycle_count = 0;

  ip_stride_prefetcher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .access_address(access_address), .instr_pointer(instr_pointer),
    .out_valid(out_valid), .out_ready(out_ready),
    .prefetch_address(prefetch_address), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every output transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_prefetch(prefetch_address, last_of_run);
  end

  // Receiver: drop ready at random, or hold it off entirely during pressure.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one access; hold it until the transfer, then note it. Valid stays
  // high afterwards until the next call or idle_input decides.
  task automatic send_access(logic [63:0] addr, logic [63:0] ip);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    access_address <= addr;
    instr_pointer <= ip;
    do @(posedge clk); while (!in_ready);
    sb.note_access(addr, ip);
  endtask

  // Drop valid after the last access of a sequence.
  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_degree(logic [3:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'(REG_DEGREE) << 2;
    pwdata <= {28'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.degree = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every expected prefetch arrived, plus slack for the pipeline.
  task automatic drain();
    idle_input();
    while (sb.pending_addr.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // A stride run on one ip: a miss, a new stride, then repeats.
  task automatic stride_run(logic [63:0] ip, int len);
    logic [63:0] page;
    logic [63:0] stride;
    page = {$urandom, $urandom} >> PgShift;
    case ($urandom_range(3))
      0: stride = 64'($urandom_range(1, 4));
      1: stride = -64'($urandom_range(1, 4));
      2: stride = {{32{1'b0}}, $urandom};
      default: stride = {$urandom, $urandom};
    endcase
    for (int i = 0; i < len; i++) begin
      send_access((page << PgShift) | 64'($urandom_range(4095)), ip);
      page += stride;
    end
  endtask

  task automatic random_phase(int n_runs);
    logic [63:0] ip;
    for (int r = 0; r < n_runs; r++) begin
      if ($urandom_range(9) < 8) begin
        ip = ($urandom_range(3) == 0) ? 64'(r % 5) : {$urandom, $urandom};
        stride_run(ip, $urandom_range(2, 5));
      end else begin
        send_access({$urandom, $urandom}, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    access_address = '0;
    instr_pointer = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ip zero hits tracker 0, zero stride, wrap, extreme fields.
    send_access(64'h0, 64'h0);
    send_access(64'h0000_0000_0000_1fff, 64'h0);
    send_access(64'h0000_0000_0000_1000, 64'h0);
    send_access(64'h0000_0000_0000_2000, 64'h0);
    send_access(64'h0000_0000_0000_3abc, 64'h0);
    send_access(64'hffff_ffff_ffff_d000, 64'hffff_ffff_ffff_ffff);
    send_access(64'hffff_ffff_ffff_e123, 64'hffff_ffff_ffff_ffff);
    send_access(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_access(64'h0000_0000_0000_5000, 64'haaaa_5555_aaaa_5555);
    send_access(64'h0000_0000_0000_3000, 64'haaaa_5555_aaaa_5555);
    send_access(64'h0000_0000_0000_1000, 64'haaaa_5555_aaaa_5555);
    drain();
    write_degree(4'd8);
    send_access(64'h0000_0000_0000_0fff, 64'haaaa_5555_aaaa_5555);
    drain();
    write_degree(4'd0);
    send_access(64'hffff_ffff_ffff_f000, 64'haaaa_5555_aaaa_5555);
    drain();
    write_degree(4'd15);
    send_access(64'hffff_ffff_ffff_e000, 64'haaaa_5555_aaaa_5555);
    drain();

    // Several settings, each with its own idling profile.
    write_degree(4'd3);
    random_phase(12);
    drain();
    send_idle_pct = 88;
    write_degree(4'd1);
    random_phase(12);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 88;
    write_degree(4'd8);
    random_phase(12);
    drain();
    send_idle_pct = 24;
    recv_stall_pct = 24;
    write_degree(4'd5);
    random_phase(12);
    drain();

    // Pressure: hold off the receiver while the sender keeps offering.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_degree(4'd8);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        stride_run(64'h1234, 8);
        idle_input();
      end
    join
    drain();

    if (sb.errors == 0 && sb.pending_addr.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
